FILE: design/htrd_pkg.sv
`timescale 1ns / 1ps

package htrd_pkg;

    // Raw word and full-scale divisor
    localparam int          RAW_W    = 16;
    localparam logic [15:0] RAW_FULL = 16'hFFFF;

    // Datapath widths: magnitude of raw*span, magnitude scaled by 10^d, quotient
    localparam int MAG_W = 24;
    localparam int SCL_W = 30;
    localparam int EST_W = SCL_W - RAW_W + 1;
    localparam int Q_W   = SCL_W - RAW_W;

    // Temperature span and offset (offset already multiplied by the full scale)
    localparam logic [MAG_W-1:0] TEMP_SPAN       = 24'd175;
    localparam logic [MAG_W-1:0] TEMP_OFFSET_NUM = 24'd2949075;
    localparam logic [MAG_W-1:0] HUMID_SPAN      = 24'd100;

    // Decimal digit count codes
    localparam logic [1:0] DIG_0 = 2'd0;
    localparam logic [1:0] DIG_1 = 2'd1;
    localparam logic [1:0] DIG_2 = 2'd2;
    localparam logic [1:0] DIG_3 = 2'd3;

    // Load enables for the two divider stages
    typedef struct packed {
        logic est;
        logic fix;
    } div_en_t;

endpackage

FILE: design/htrd_div65535.sv
`timescale 1ns / 1ps

module htrd_div65535
    import htrd_pkg::*;
(
    input  logic             clk,
    input  div_en_t          en,
    input  logic [SCL_W-1:0] x,
    output logic [Q_W-1:0]   q
);

    logic [SCL_W-1:0] x_reg;
    logic [EST_W-1:0] est_reg;
    logic [Q_W-1:0]   q_reg;
    logic [SCL_W:0]   est_sum;
    logic [EST_W-1:0] est_next;
    logic [SCL_W:0]   rem;
    logic [EST_W-1:0] q_next;

    // Estimate: x/65535 = a + (a+b)/65535 with x = 65536a + b; off by at most one
    assign est_sum  = {1'b0, x} + (SCL_W+1)'(x[SCL_W-1:RAW_W]);
    assign est_next = est_sum[SCL_W:RAW_W];

    always_ff @(posedge clk)
    begin
        if (en.est)
        begin
            x_reg   <= x;
            est_reg <= est_next;
        end
    end

    // Correct: remainder x - est*65535 lies below twice the divisor
    assign rem    = {1'b0, x_reg} + (SCL_W+1)'(est_reg) - {est_reg, {RAW_W{1'b0}}};
    assign q_next = est_reg + EST_W'(rem >= (SCL_W+1)'(RAW_FULL));

    always_ff @(posedge clk)
    begin
        if (en.fix)
        begin
            q_reg <= q_next[Q_W-1:0];
        end
    end

    assign q = q_reg;

endmodule

FILE: design/humidity_temp_raw_to_decimal.sv
// Throughput: one item per cycle while m_axis_tready does not stall the output;
// five register stages (input scale, digit scale, quotient estimate, quotient
// correction, output) each hold one item.
// Reset (rst_n low, asynchronous) empties every stage and sets the digit
// count to two.
`timescale 1ns / 1ps

module humidity_temp_raw_to_decimal
    import htrd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] temp_raw, [31:16] humid_raw
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [8:0] temp_whole, [16:9] temp_fraction, [23:17] humid_whole,
    // [30:24] humid_fraction, [31] zero
    output logic [31:0] m_axis_tdata
);

    logic [1:0] digits_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    // Stage 1 payload
    logic [MAG_W-1:0] tmag1_reg, hmag1_reg;
    logic             neg1_reg, tz1_reg, hz1_reg;
    logic [1:0]       dig1_reg;
    // Stage 2 payload
    logic [SCL_W-1:0] tw2_reg, ts2_reg, hw2_reg, hs2_reg;
    logic             neg2_reg, tz2_reg, hz2_reg;
    logic [1:0]       dig2_reg;
    // Flags through the divider stages
    logic             neg3_reg, tz3_reg, hz3_reg;
    logic [1:0]       dig3_reg;
    logic             neg4_reg, tz4_reg, hz4_reg;
    logic [1:0]       dig4_reg;
    // Output stage
    logic [31:0]      out_reg;

    logic [MAG_W-1:0] tprod, tmag_next, hmag_next;
    logic             neg_next;
    logic [1:0]       dig_next;
    logic [SCL_W-1:0] tw_ext, hw_ext, ts_next, hs_next;
    logic [Q_W-1:0]   qtw, qts, qhw, qhs;
    logic [Q_W-1:0]   tws_scaled, hws_scaled, tfrac_mag, hfrac_mag;
    logic [8:0]       temp_whole_next;
    logic [7:0]       temp_frac_next;
    logic [6:0]       humid_whole_next, humid_frac_next;
    logic [31:0]      out_next;
    div_en_t          div_en;

    // Hold the digit count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            digits_reg <= DIG_2;
        else if (cfg_we)
            digits_reg <= cfg_wdata;
    end

    // Advance a stage when it is empty or the next one advances
    assign rdy5          = !v5_reg || m_axis_tready;
    assign rdy4          = !v4_reg || rdy5;
    assign rdy3          = !v3_reg || rdy4;
    assign rdy2          = !v2_reg || rdy3;
    assign rdy1          = !v1_reg || rdy2;
    assign s_axis_tready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= s_axis_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // Stage 1: raw*span, magnitude and sign of the temperature numerator, digit code 3 capped to 2
    assign tprod     = MAG_W'(s_axis_tdata[15:0]) * TEMP_SPAN;
    assign neg_next  = tprod < TEMP_OFFSET_NUM;
    assign tmag_next = neg_next ? (TEMP_OFFSET_NUM - tprod) : (tprod - TEMP_OFFSET_NUM);
    assign hmag_next = MAG_W'(s_axis_tdata[31:16]) * HUMID_SPAN;
    assign dig_next  = (digits_reg == DIG_3) ? DIG_2 : digits_reg;

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            tmag1_reg <= tmag_next;
            hmag1_reg <= hmag_next;
            neg1_reg  <= neg_next;
            tz1_reg   <= (s_axis_tdata[15:0] == 16'd0);
            hz1_reg   <= (s_axis_tdata[31:16] == 16'd0);
            dig1_reg  <= dig_next;
        end
    end

    // Stage 2: scale magnitudes by 10^digits
    assign tw_ext = SCL_W'(tmag1_reg);
    assign hw_ext = SCL_W'(hmag1_reg);

    always_comb
    begin
        case (dig1_reg)
            DIG_0:
            begin
                ts_next = tw_ext;
                hs_next = hw_ext;
            end
            DIG_1:
            begin
                ts_next = (tw_ext << 3) + (tw_ext << 1);
                hs_next = (hw_ext << 3) + (hw_ext << 1);
            end
            default:
            begin
                ts_next = (tw_ext << 6) + (tw_ext << 5) + (tw_ext << 2);
                hs_next = (hw_ext << 6) + (hw_ext << 5) + (hw_ext << 2);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            tw2_reg  <= tw_ext;
            ts2_reg  <= ts_next;
            hw2_reg  <= hw_ext;
            hs2_reg  <= hs_next;
            neg2_reg <= neg1_reg;
            tz2_reg  <= tz1_reg;
            hz2_reg  <= hz1_reg;
            dig2_reg <= dig1_reg;
        end
    end

    // Stages 3 and 4: divide by the full scale
    assign div_en.est = rdy3;
    assign div_en.fix = rdy4;

    htrd_div65535 u_div_tw (.clk(clk), .en(div_en), .x(tw2_reg), .q(qtw));
    htrd_div65535 u_div_ts (.clk(clk), .en(div_en), .x(ts2_reg), .q(qts));
    htrd_div65535 u_div_hw (.clk(clk), .en(div_en), .x(hw2_reg), .q(qhw));
    htrd_div65535 u_div_hs (.clk(clk), .en(div_en), .x(hs2_reg), .q(qhs));

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            neg3_reg <= neg2_reg;
            tz3_reg  <= tz2_reg;
            hz3_reg  <= hz2_reg;
            dig3_reg <= dig2_reg;
        end
        if (rdy4)
        begin
            neg4_reg <= neg3_reg;
            tz4_reg  <= tz3_reg;
            hz4_reg  <= hz3_reg;
            dig4_reg <= dig3_reg;
        end
    end

    // Stage 5: decimal part = scaled quotient - whole*10^digits, then apply sign
    always_comb
    begin
        case (dig4_reg)
            DIG_0:
            begin
                tws_scaled = qtw;
                hws_scaled = qhw;
            end
            DIG_1:
            begin
                tws_scaled = (qtw << 3) + (qtw << 1);
                hws_scaled = (qhw << 3) + (qhw << 1);
            end
            default:
            begin
                tws_scaled = (qtw << 6) + (qtw << 5) + (qtw << 2);
                hws_scaled = (qhw << 6) + (qhw << 5) + (qhw << 2);
            end
        endcase
    end

    assign tfrac_mag = tz4_reg ? '0 : (qts - tws_scaled);
    assign hfrac_mag = hz4_reg ? '0 : (qhs - hws_scaled);

    assign temp_whole_next  = neg4_reg ? (9'd0 - qtw[8:0]) : qtw[8:0];
    assign temp_frac_next   = neg4_reg ? (8'd0 - {1'b0, tfrac_mag[6:0]})
                                       : {1'b0, tfrac_mag[6:0]};
    assign humid_whole_next = qhw[6:0];
    assign humid_frac_next  = hfrac_mag[6:0];

    assign out_next = {1'b0, humid_frac_next, humid_whole_next,
                       temp_frac_next, temp_whole_next};

    always_ff @(posedge clk)
    begin
        if (rdy5)
            out_reg <= out_next;
    end

    assign m_axis_tvalid = v5_reg;
    assign m_axis_tdata  = out_reg;

endmodule

FILE: design/htrd_checker.sv
`timescale 1ns / 1ps

module htrd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // Hold a stalled result until it transfers
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Temperature whole part stays within -45..130
    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[8:0]) >= -9'sd45 &&
                           $signed(m_axis_tdata[8:0]) <= 9'sd130))
        else $error("temperature whole part out of range");

    // Humidity parts stay within range and the pad bit is zero
    a_humid_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[23:17] <= 7'd100 &&
                           m_axis_tdata[30:24] <= 7'd99 && !m_axis_tdata[31]))
        else $error("humidity field out of range");

    // Negative temperature fraction only comes with a non-positive whole part
    a_temp_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[16]) |-> (m_axis_tdata[8] ||
                                                 m_axis_tdata[8:0] == 9'd0))
        else $error("temperature fraction sign disagrees with whole part");

endmodule

bind humidity_temp_raw_to_decimal htrd_checker u_htrd_checker (.*);
